[rtl/one_shot_timer_table_top_assert.svh]
// Assertion macros shared by the timer table modules.
// Needs clk and arst_n in the scope of each use.
`ifndef ONE_SHOT_TIMER_TABLE_TOP_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define OTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ott_pkg.sv]
// Types and constants of the one-shot timer table.
// No dependencies.
package ott_pkg;

	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	localparam logic [3:0] OP_ADD_ASYNC = 4'd0;
	localparam logic [3:0] OP_ADD_SYNC  = 4'd1;
	localparam logic [3:0] OP_ADD_PER   = 4'd2;
	localparam logic [3:0] OP_KILL      = 4'd3;
	localparam logic [3:0] OP_TICK      = 4'd4;
	localparam logic [3:0] OP_PAUSE     = 4'd5;
	localparam logic [3:0] OP_RESUME    = 4'd6;
	localparam logic [3:0] OP_RELOAD    = 4'd7;
	localparam logic [3:0] OP_CLEAR     = 4'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic [7:0] PAUSE_MAX = 8'hFF;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [15:0] frame_count;
		logic [15:0] timer_tag;
	} in_item_t;

	typedef struct packed {
		logic        is_fire;
		logic [15:0] fired_tag;
		logic        fired_queue;
		logic [1:0]  status_code;
		logic [5:0]  active_count;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		OK_ADD, OK_KILL, OK_TICK, OK_PAUSE, OK_RESUME, OK_RELOAD, OK_CLEAR, OK_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        queue;
		logic [15:0] reload;
		logic [15:0] frames;
		logic [15:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] frames;
		logic [7:0]  pause;
		logic        queue;
		logic [15:0] reload;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [15:0]      tag;
		logic             queue;
	} fire_wr_t;

	typedef struct packed {
		logic             vld;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] nfire;
	} done_t;

	typedef enum logic [0:0] {ES_IDLE, ES_WALK} eng_state_t;

	typedef enum logic [1:0] {EM_IDLE, EM_FETCH, EM_SHOW} em_state_t;

endpackage

[rtl/ott_front.sv]
// Front end: two-entry command queue that decodes opcodes on entry.
// Depends on ott_pkg.
module ott_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ott_pkg::in_item_t item,
	output logic             cmd_valid,
	output ott_pkg::cmd_t    cmd,
	input  logic             cmd_pop
);
	import ott_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		dec.queue  = 1'b0;
		dec.reload = '0;
		dec.frames = item.frame_count;
		dec.tag    = item.timer_tag;
		case (item.opcode)
			OP_ADD_ASYNC: dec.kind = OK_ADD;
			OP_ADD_SYNC: begin
				dec.kind  = OK_ADD;
				dec.queue = 1'b1;
			end
			OP_ADD_PER: begin
				dec.kind   = OK_ADD;
				dec.queue  = 1'b1;
				dec.reload = item.frame_count;
			end
			OP_KILL:   dec.kind = OK_KILL;
			OP_TICK:   dec.kind = OK_TICK;
			OP_PAUSE:  dec.kind = OK_PAUSE;
			OP_RESUME: dec.kind = OK_RESUME;
			OP_RELOAD: dec.kind = OK_RELOAD;
			OP_CLEAR:  dec.kind = OK_CLEAR;
			default:   dec.kind = OK_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

[rtl/ott_engine.sv]
// Back end: timer table memory and the walk that updates and compacts it.
// Depends on ott_pkg and the assertion macro header.
`include "one_shot_timer_table_top_assert.svh"
module ott_engine #(
	parameter int MAX_TIMERS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  ott_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             emit_busy,
	output ott_pkg::fire_wr_t fire_wr,
	output ott_pkg::done_t   done
);
	import ott_pkg::*;

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_TIMERS);

	entry_t     tbl [MAX_TIMERS];
	entry_t     rdat_s1;
	logic       rv_s1;
	eng_state_t state_q, state_d;
	cmd_t       cmd_q;
	logic [CW-1:0] live_q, rd_q, wr_q, fcnt_q;
	logic       found_q;

	logic          start, is_walk, rd_issue, drop, fire, last_proc, found_d;
	entry_t        upd;
	logic [CW-1:0] wr_d, fcnt_d;
	logic          we;
	logic [IW-1:0] wa;
	entry_t        wd;

	assign start   = (state_q == ES_IDLE) && cmd_valid && !emit_busy;
	assign cmd_pop = start;
	assign is_walk = (cmd.kind == OK_KILL) || (cmd.kind == OK_TICK) ||
		(cmd.kind == OK_PAUSE) || (cmd.kind == OK_RESUME) || (cmd.kind == OK_RELOAD);
	assign rd_issue  = (state_q == ES_WALK) && (rd_q < live_q);
	assign last_proc = rv_s1 && (rd_q == live_q);

	always_comb begin
		upd     = rdat_s1;
		drop    = 1'b0;
		fire    = 1'b0;
		found_d = found_q;
		case (cmd_q.kind)
			OK_KILL: begin
				if (!found_q && (rdat_s1.tag == cmd_q.tag)) begin
					drop    = 1'b1;
					found_d = 1'b1;
				end
			end
			OK_TICK: begin
				if (rdat_s1.pause == 8'd0) begin
					if (rdat_s1.frames <= 16'd1) begin
						drop = 1'b1;
						fire = 1'b1;
					end else begin
						upd.frames = rdat_s1.frames - 16'd1;
					end
				end
			end
			OK_PAUSE: begin
				if (rdat_s1.pause != PAUSE_MAX) begin
					upd.pause = rdat_s1.pause + 8'd1;
				end
			end
			OK_RESUME: begin
				if (rdat_s1.pause != 8'd0) begin
					upd.pause = rdat_s1.pause - 8'd1;
				end
			end
			OK_RELOAD: begin
				if (rdat_s1.reload != 16'd0) begin
					upd.frames = rdat_s1.reload;
				end
			end
			default: ;
		endcase
		if (!rv_s1) begin
			drop    = 1'b0;
			fire    = 1'b0;
			found_d = found_q;
		end
	end

	assign wr_d   = wr_q + {{(CW-1){1'b0}}, rv_s1 && !drop};
	assign fcnt_d = fcnt_q + {{(CW-1){1'b0}}, fire};

	always_comb begin
		we = 1'b0;
		wa = wr_q[IW-1:0];
		wd = upd;
		if (state_q == ES_IDLE) begin
			we        = start && (cmd.kind == OK_ADD) && (live_q < MAXC);
			wa        = live_q[IW-1:0];
			wd.tag    = cmd.tag;
			wd.frames = cmd.frames;
			wd.pause  = 8'd0;
			wd.queue  = cmd.queue;
			wd.reload = cmd.reload;
		end else begin
			we = rv_s1 && !drop;
		end
	end

	always_comb begin
		fire_wr.we    = fire;
		fire_wr.idx   = IDX_W'(fcnt_q);
		fire_wr.tag   = rdat_s1.tag;
		fire_wr.queue = rdat_s1.queue;
	end

	always_comb begin
		done.vld    = 1'b0;
		done.status = ST_OK;
		done.count  = CNT_W'(live_q);
		done.nfire  = '0;
		if (state_q == ES_IDLE) begin
			done.vld = start && !(is_walk && (live_q != '0));
			case (cmd.kind)
				OK_ADD: begin
					if (live_q < MAXC) begin
						done.count = CNT_W'(live_q) + CNT_W'(1);
					end else begin
						done.status = ST_FULL;
					end
				end
				OK_KILL:  done.status = ST_NOTFOUND;
				OK_CLEAR: done.count  = '0;
				default: ;
			endcase
		end else begin
			done.vld   = last_proc;
			done.count = CNT_W'(wr_d);
			done.nfire = CNT_W'(fcnt_d);
			if ((cmd_q.kind == OK_KILL) && !found_d) begin
				done.status = ST_NOTFOUND;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ES_IDLE: begin
				if (start && is_walk && (live_q != '0)) begin
					state_d = ES_WALK;
				end
			end
			ES_WALK: begin
				if (last_proc) begin
					state_d = ES_IDLE;
				end
			end
			default: state_d = ES_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tbl[wa] <= wd;
		end
		rdat_s1 <= tbl[rd_q[IW-1:0]];
		if (start) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ES_IDLE;
			live_q  <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			fcnt_q  <= '0;
			found_q <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_issue;
			if (state_q == ES_IDLE) begin
				rd_q    <= '0;
				wr_q    <= '0;
				fcnt_q  <= '0;
				found_q <= 1'b0;
				if (done.vld) begin
					live_q <= CW'(done.count);
				end
			end else begin
				if (rd_issue) begin
					rd_q <= rd_q + CW'(1);
				end
				wr_q    <= wr_d;
				fcnt_q  <= fcnt_d;
				found_q <= found_d;
				if (last_proc) begin
					live_q <= wr_d;
				end
			end
		end
	end

	`OTT_ASSERT_NOW(a_live_bound, 1'b1, live_q <= MAXC, "live count above table size")
	`OTT_ASSERT_NOW(a_wr_behind_rd, state_q == ES_WALK, wr_q <= rd_q, "write index passed read")
	`OTT_ASSERT_NEXT(a_walk_ends, (state_q == ES_WALK) && last_proc, state_q == ES_IDLE,
		"walk did not end")

endmodule

[rtl/ott_emit.sv]
// Result side: fire record buffer and the sequencer that presents results.
// Depends on ott_pkg and the assertion macro header.
`include "one_shot_timer_table_top_assert.svh"
module ott_emit #(
	parameter int MAX_TIMERS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ott_pkg::fire_wr_t fire_wr,
	input  ott_pkg::done_t    done,
	output logic              busy,
	output logic              empty,
	input  logic              pop,
	output ott_pkg::out_item_t result
);
	import ott_pkg::*;

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	typedef struct packed {
		logic [15:0] tag;
		logic        queue;
	} fire_rec_t;

	fire_rec_t        fbuf [MAX_TIMERS];
	fire_rec_t        frd_q;
	em_state_t        state_q, state_d;
	logic [CNT_W-1:0] p_q, nf_q, cnt_q;
	logic [1:0]       st_q;
	logic             has_fire;

	assign has_fire = (p_q < nf_q);
	assign busy     = (state_q != EM_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_IDLE: begin
				if (done.vld) begin
					state_d = EM_FETCH;
				end
			end
			EM_FETCH: state_d = EM_SHOW;
			EM_SHOW: begin
				if (pop) begin
					state_d = has_fire ? EM_FETCH : EM_IDLE;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	always_comb begin
		empty               = (state_q != EM_SHOW);
		result.is_fire      = has_fire;
		result.fired_tag    = has_fire ? frd_q.tag : 16'd0;
		result.fired_queue  = has_fire ? frd_q.queue : 1'b0;
		result.status_code  = has_fire ? ST_OK : st_q;
		result.active_count = cnt_q[5:0];
		result.last         = !has_fire;
	end

	always_ff @(posedge clk) begin
		if (fire_wr.we) begin
			fbuf[fire_wr.idx[IW-1:0]] <= '{tag: fire_wr.tag, queue: fire_wr.queue};
		end
		frd_q <= fbuf[p_q[IW-1:0]];
		if (done.vld) begin
			nf_q  <= done.nfire;
			cnt_q <= done.count;
			st_q  <= done.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == EM_IDLE) begin
				p_q <= '0;
			end else if ((state_q == EM_SHOW) && pop && has_fire) begin
				p_q <= p_q + CNT_W'(1);
			end
		end
	end

	`OTT_ASSERT_NOW(a_done_when_idle, done.vld, state_q == EM_IDLE, "done while results pending")
	`OTT_ASSERT_NOW(a_last_is_status, !empty && result.last, !result.is_fire,
		"last beat carries a fire")
	`OTT_ASSERT_NEXT(a_fetch_shows, state_q == EM_FETCH, state_q == EM_SHOW,
		"fetch not followed by show")

endmodule

[rtl/one_shot_timer_table_top.sv]
// Channel   | Handshake       | Payload
// item      | push / full     | in_item_t: opcode, frame_count, timer_tag
// result    | pop / empty     | out_item_t: fire events, then one status beat
//
// Add, clear and unknown ops finish in the engine's idle state; kill, tick, pause,
// resume and reload walk the table one entry per cycle (no walk if the table is empty).
// Each result beat passes through the output sequencer's fetch state (buffer read), then its show state.
// The engine starts the next op only after all beats of the previous op are popped;
// a two-entry command queue keeps accepting items meanwhile.
// Reset: live count zero, queues empty; table contents need no clearing.
// Depends on ott_pkg, ott_front, ott_engine and ott_emit.
module one_shot_timer_table_top #(
	parameter int MAX_TIMERS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ott_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output ott_pkg::out_item_t result
);
	import ott_pkg::*;

	logic     cmd_valid;
	logic     cmd_pop;
	cmd_t     cmd;
	logic     emit_busy;
	fire_wr_t fire_wr;
	done_t    done;

	ott_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ott_engine #(.MAX_TIMERS(MAX_TIMERS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.emit_busy (emit_busy),
		.fire_wr   (fire_wr),
		.done      (done)
	);

	ott_emit #(.MAX_TIMERS(MAX_TIMERS)) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire_wr (fire_wr),
		.done    (done),
		.busy    (emit_busy),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[sim/testbench.sv]
// Self-checking testbench for one_shot_timer_table_top: drives op beats through the
// push/full queue, predicts fire and status beats from its own model of the table.
// Depends on ott_pkg and the one_shot_timer_table_top RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ott_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_item_t item = '0;
	out_item_t result;

	one_shot_timer_table_top #(.MAX_TIMERS(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #4 clk = ~clk;

	entry_t timers[TABLE_DEPTH];
	int live_timers = 0;
	out_item_t pending_beats[$];
	int mismatches = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit long_hold = 1'b0;
	bit quiet_tail = 1'b0;

	function automatic void drop_timer(int pos);
		for (int j = pos; j < live_timers - 1; j++)
			timers[j] = timers[j + 1];
		live_timers--;
	endfunction

	function automatic void predict_op(in_item_t it);
		logic [1:0] status;
		out_item_t beat;
		out_item_t beats[$];
		int i;
		status = ST_OK;
		case (it.opcode)
			OP_ADD_ASYNC, OP_ADD_SYNC, OP_ADD_PER: begin
				if (live_timers >= TABLE_DEPTH) begin
					status = ST_FULL;
				end else begin
					timers[live_timers].tag = it.timer_tag;
					timers[live_timers].frames = it.frame_count;
					timers[live_timers].pause = '0;
					timers[live_timers].queue = (it.opcode != OP_ADD_ASYNC);
					timers[live_timers].reload = (it.opcode == OP_ADD_PER) ? it.frame_count : '0;
					live_timers++;
				end
			end
			OP_KILL: begin
				status = ST_NOTFOUND;
				for (i = 0; i < live_timers; i++)
					if (timers[i].tag == it.timer_tag) begin
						drop_timer(i);
						status = ST_OK;
						break;
					end
			end
			OP_TICK: begin
				i = 0;
				while (i < live_timers) begin
					if (timers[i].pause == 0) begin
						if (timers[i].frames <= 1) begin
							beat = '0;
							beat.is_fire = 1'b1;
							beat.fired_tag = timers[i].tag;
							beat.fired_queue = timers[i].queue;
							beats.push_back(beat);
							drop_timer(i);
							continue;
						end
						timers[i].frames--;
					end
					i++;
				end
			end
			OP_PAUSE:
				for (i = 0; i < live_timers; i++)
					if (timers[i].pause != PAUSE_MAX) timers[i].pause++;
			OP_RESUME:
				for (i = 0; i < live_timers; i++)
					if (timers[i].pause != 0) timers[i].pause--;
			OP_RELOAD:
				for (i = 0; i < live_timers; i++)
					if (timers[i].reload != 0) timers[i].frames = timers[i].reload;
			OP_CLEAR: live_timers = 0;
			default: ;
		endcase
		beat = '0;
		beat.status_code = status;
		beat.last = 1'b1;
		beats.push_back(beat);
		foreach (beats[k]) begin
			beats[k].active_count = live_timers[5:0];
			pending_beats.push_back(beats[k]);
		end
	endfunction

	task automatic send_op(logic [3:0] op, logic [15:0] frames, logic [15:0] tag);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item <= '{opcode: op, frame_count: frames, timer_tag: tag};
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_op('{opcode: op, frame_count: frames, timer_tag: tag});
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending_beats.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (long_hold) begin
			long_hold = 1'b0;
			hold_cycles <= 300;
			pop <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			hold_cycles <= $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else if (arst_n && pop && !empty) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", result);
			end else begin
				if (result !== pending_beats[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", pending_beats[0], result);
				end
				void'(pending_beats.pop_front());
			end
		end
	end

	task automatic test_directed();
		send_op(OP_TICK, 16'd0, 16'd0);
		send_op(OP_KILL, 16'd0, 16'h1234);
		send_op(OP_ADD_ASYNC, 16'd0, 16'hFFFF);
		send_op(OP_ADD_SYNC, 16'd1, 16'h0000);
		send_op(OP_ADD_PER, 16'd2, 16'h5555);
		send_op(OP_ADD_PER, 16'hFFFF, 16'hAAAA);
		send_op(OP_ADD_ASYNC, 16'd3, 16'h5555);
		send_op(OP_PAUSE, 16'd0, 16'd0);
		send_op(OP_TICK, 16'd0, 16'd0);
		send_op(OP_RESUME, 16'd0, 16'd0);
		send_op(OP_RESUME, 16'd0, 16'd0);
		send_op(OP_TICK, 16'd0, 16'd0);
		send_op(OP_KILL, 16'd0, 16'h5555);
		send_op(OP_RELOAD, 16'd0, 16'd0);
		send_op(OP_TICK, 16'd0, 16'd0);
		send_op(4'd9, 16'hFFFF, 16'hFFFF);
		send_op(4'd15, 16'd0, 16'd0);
		send_op(OP_CLEAR, 16'd0, 16'd0);
		send_op(OP_TICK, 16'd0, 16'd0);
	endtask

	task automatic test_full_table();
		long_hold = 1'b1;
		for (int i = 0; i < TABLE_DEPTH + 1; i++)
			send_op(OP_ADD_SYNC, 16'd1, i[15:0]);
		send_op(OP_TICK, 16'd0, 16'd0);
		wait_drained();
	endtask

	task automatic test_pause_saturation();
		send_op(OP_ADD_ASYNC, 16'd1, 16'h0077);
		for (int i = 0; i < 257; i++) send_op(OP_PAUSE, 16'd0, 16'd0);
		for (int i = 0; i < 2; i++) send_op(OP_RESUME, 16'd0, 16'd0);
		send_op(OP_TICK, 16'd0, 16'd0);
		send_op(OP_CLEAR, 16'd0, 16'd0);
	endtask

	task automatic test_random();
		logic [3:0] op;
		for (int n = 0; n < 95; n++) begin
			if (n == 75) quiet_tail = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3: op = OP_ADD_ASYNC;
				4, 5: op = OP_ADD_SYNC;
				6, 7: op = OP_ADD_PER;
				8, 9: op = OP_KILL;
				10, 11, 12, 13, 14: op = OP_TICK;
				15: op = OP_PAUSE;
				16: op = OP_RESUME;
				17: op = OP_RELOAD;
				18: op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_TICK;
				default: op = 4'($urandom_range(9, 15));
			endcase
			send_op(op, ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_pause_saturation();
		test_random();
		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
